[design/mbps_pkg.sv]
`default_nettype none
package mbps_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int PATTERN_STORED = 16;
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W = 5;
    localparam int BYTE_W = 8;
    localparam int OFF_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int MASK_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd3;

    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_UNIQUE = 2'd1;
    localparam logic [1:0] STATUS_MULTI = 2'd2;

    localparam logic [CFG_DATA_W-1:0] PAT_RESET = '0;
    localparam logic [MASK_W-1:0] CARE_RESET = 16'hffff;
    localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pat_lo;
        logic [CFG_DATA_W-1:0] pat_hi;
        logic [MASK_W-1:0] care;
        logic [LEN_W-1:0] len;
    } pat_cfg_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } shift_ctl_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] len;
        len = raw;
        if (raw == '0)
        begin
            len = LEN_W'(1);
        end
        else if (int'(raw) > PATTERN_MAX)
        begin
            len = LEN_W'(PATTERN_MAX);
        end
        return len;
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(input pat_cfg_t cfg,
                                                       input logic [IDX_W-1:0] p);
        logic [2*CFG_DATA_W-1:0] flat;
        int idx;
        logic [BYTE_W-1:0] want;
        flat = {cfg.pat_hi, cfg.pat_lo};
        idx = int'(p);
        want = '0;
        if (idx < PATTERN_STORED)
        begin
            want = flat[idx*BYTE_W +: BYTE_W];
        end
        return want;
    endfunction

    function automatic logic pattern_care(input pat_cfg_t cfg, input logic [IDX_W-1:0] p);
        int idx;
        logic care;
        idx = int'(p);
        care = 1'b0;
        if (idx < PATTERN_STORED)
        begin
            care = cfg.care[idx];
        end
        return care;
    endfunction

endpackage
`default_nettype wire

[design/mbps_cell.sv]
`default_nettype none
module mbps_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mbps_pkg::shift_ctl_t          ctl,
    input  wire mbps_pkg::pat_cfg_t            cfg,
    input  wire logic [mbps_pkg::IDX_W-1:0]    cell_index,
    input  wire logic [mbps_pkg::BYTE_W-1:0]   byte_in,
    input  wire logic                          valid_in,
    output logic [mbps_pkg::BYTE_W-1:0]        byte_out,
    output logic                               valid_out,
    output logic                               cell_ok
);

    logic [mbps_pkg::BYTE_W-1:0] byte_reg;
    logic [mbps_pkg::BYTE_W-1:0] byte_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic                        active;
    logic [mbps_pkg::IDX_W-1:0]  pat_idx;
    logic [mbps_pkg::BYTE_W-1:0] want;
    logic                        care;

    // The byte entering this cell is compared with the pattern byte that lines up here.
    always_comb
    begin
        active = int'(cell_index) < int'(cfg.len);
        pat_idx = mbps_pkg::IDX_W'(int'(cfg.len) - 1 - int'(cell_index));
        want = mbps_pkg::pattern_byte(cfg, pat_idx);
        care = mbps_pkg::pattern_care(cfg, pat_idx);
        cell_ok = !active || (valid_in && (!care || byte_in == want));
    end

    always_comb
    begin
        byte_next = byte_reg;
        valid_next = valid_reg;
        if (ctl.shift)
        begin
            byte_next = byte_in;
            valid_next = valid_in && !ctl.clear;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;
    assign valid_out = valid_reg;

endmodule
`default_nettype wire

[design/masked_byte_pattern_search.sv]
// The result word is registered: it appears in the cycle after the byte that ends the search.
// Throughput: one byte per cycle; the cell row compares each byte in the cycle it is accepted and shifts it in.
// A pending result word stalls input only while out_ready stays low.
// Reset clears the window, the hit state and the output valid flag; the pattern registers return
// to an all-zero pattern, a full care mask and a length of one.
`default_nettype none
module masked_byte_pattern_search (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [mbps_pkg::BYTE_W-1:0]       data_byte,
    input  wire logic [mbps_pkg::OFF_W-1:0]        file_offset,
    input  wire logic                              range_end,
    input  wire logic                              search_end,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [1:0]                             status,
    output logic [mbps_pkg::OFF_W-1:0]             match_offset
);

    logic [mbps_pkg::CFG_DATA_W-1:0] pat_lo_reg;
    logic [mbps_pkg::CFG_DATA_W-1:0] pat_hi_reg;
    logic [mbps_pkg::MASK_W-1:0]     care_reg;
    logic [mbps_pkg::LEN_W-1:0]      len_reg;
    mbps_pkg::pat_cfg_t              cfg;
    mbps_pkg::shift_ctl_t            ctl;

    logic [mbps_pkg::BYTE_W-1:0] byte_chain [mbps_pkg::PATTERN_MAX+1];
    logic                        valid_chain [mbps_pkg::PATTERN_MAX+1];
    logic [mbps_pkg::PATTERN_MAX-1:0] ok_vec;

    logic                       accept;
    logic                       hit;
    logic [1:0]                 hit_count_reg;
    logic [1:0]                 hit_count_next;
    logic [mbps_pkg::OFF_W-1:0] first_hit_reg;
    logic [mbps_pkg::OFF_W-1:0] first_hit_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [1:0]                 status_reg;
    logic [1:0]                 status_next;
    logic [mbps_pkg::OFF_W-1:0] match_offset_reg;
    logic [mbps_pkg::OFF_W-1:0] match_offset_next;
    logic [mbps_pkg::OFF_W-1:0] start_offset;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= mbps_pkg::PAT_RESET;
            pat_hi_reg <= mbps_pkg::PAT_RESET;
            care_reg <= mbps_pkg::CARE_RESET;
            len_reg <= mbps_pkg::LEN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mbps_pkg::CFG_PAT_LO: pat_lo_reg <= cfg_data;
                mbps_pkg::CFG_PAT_HI: pat_hi_reg <= cfg_data;
                mbps_pkg::CFG_CARE:   care_reg <= cfg_data[mbps_pkg::MASK_W-1:0];
                mbps_pkg::CFG_LENGTH: len_reg <= cfg_data[mbps_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.pat_lo = pat_lo_reg;
        cfg.pat_hi = pat_hi_reg;
        cfg.care = care_reg;
        cfg.len = mbps_pkg::clamp_len(len_reg);
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept = in_valid && in_ready;
    assign ctl.shift = accept;
    assign ctl.clear = range_end || search_end;

    assign byte_chain[0] = data_byte;
    assign valid_chain[0] = 1'b1;

    for (genvar k = 0; k < mbps_pkg::PATTERN_MAX; k++)
    begin : g_cell
        mbps_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .cfg        (cfg),
            .cell_index (mbps_pkg::IDX_W'(k)),
            .byte_in    (byte_chain[k]),
            .valid_in   (valid_chain[k]),
            .byte_out   (byte_chain[k+1]),
            .valid_out  (valid_chain[k+1]),
            .cell_ok    (ok_vec[k])
        );
    end

    assign hit = &ok_vec;
    assign start_offset = file_offset - mbps_pkg::OFF_W'(cfg.len - mbps_pkg::LEN_W'(1));

    always_comb
    begin
        hit_count_next = hit_count_reg;
        first_hit_next = first_hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next = status_reg;
        match_offset_next = match_offset_reg;
        if (accept)
        begin
            if (hit)
            begin
                if (hit_count_reg == mbps_pkg::STATUS_NONE)
                begin
                    first_hit_next = start_offset;
                    hit_count_next = mbps_pkg::STATUS_UNIQUE;
                end
                else
                begin
                    hit_count_next = mbps_pkg::STATUS_MULTI;
                end
            end
            if (search_end)
            begin
                out_valid_next = 1'b1;
                status_next = hit_count_next;
                match_offset_next = (hit_count_next == mbps_pkg::STATUS_UNIQUE) ?
                                    first_hit_next : '0;
                hit_count_next = mbps_pkg::STATUS_NONE;
                first_hit_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_count_reg <= mbps_pkg::STATUS_NONE;
            first_hit_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hit_count_reg <= hit_count_next;
            first_hit_reg <= first_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        match_offset_reg <= match_offset_next;
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign match_offset = match_offset_reg;

    // A word that ends the search always produces a result word.
    a_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && search_end |=> out_valid_reg)
        else $error("search end did not produce a result");

    // Only a unique match carries an offset.
    a_offset_only_unique: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != mbps_pkg::STATUS_UNIQUE |-> match_offset_reg == '0)
        else $error("offset reported without a unique match");

    // A range end empties the window, so the first cell holds no valid byte.
    a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (range_end || search_end) |=> !valid_chain[1])
        else $error("window not cleared at range end");

    // The hit state is back at zero right after a search ends.
    a_hits_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept && search_end |=> hit_count_reg == mbps_pkg::STATUS_NONE)
        else $error("hit count not cleared after search end");

endmodule
`default_nettype wire
